// ===== rtl/core/spca_pkg.sv =====
package spca_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam logic [7:0] OFF_CODE_RESET = 8'd32;
	localparam logic [1:0] MAX_BYTES = 2'd2;

	// event kinds on the input channel
	typedef enum logic [1:0] {
		OP_LINK    = 2'd0,
		OP_TIMER   = 2'd1,
		OP_GENERAL = 2'd2,
		OP_SWITCH  = 2'd3
	} op_t;

	// dispatch choice made after an event
	typedef enum logic [1:0] {
		SEL_NONE    = 2'd0,
		SEL_SWITCH  = 2'd1,
		SEL_OFF     = 2'd2,
		SEL_GENERAL = 2'd3
	} sel_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_DECIDE = 2'd1,
		ST_DONE   = 2'd2
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic [1:0] byte_count;
	} in_item_t;

	typedef struct packed {
		logic       sent;
		logic [7:0] out_first;
		logic [7:0] out_second;
		logic [1:0] out_count;
		logic       restart_timer;
		logic       dropped;
	} out_item_t;

	// one queued command
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [1:0] n;
	} cmd_entry_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic decide;
		logic load;
	} dp_cmd_t;

endpackage

// ===== rtl/core/switch_paced_command_arbiter.sv =====
// Command arbiter for one serial link, paced by a switch timer.
// Input channel (in_valid/in_ready, in_data): one event per item: link ready,
// timer ready, a general command or a switch command. Commands are queued in
// two FIFOs of QUEUE_DEPTH entries; a command that meets a full FIFO is
// discarded and its result item carries dropped = 1.
// Output channel (out_valid/out_ready, out_data): exactly one result item per
// event, telling whether a command went to the link and whether the switch
// timer must be restarted.
// cfg_we/cfg_data write the solenoid-off byte (32 after reset).
// Steps: an item is accepted (flag and queue update), then decided (the
// dispatch decision with its registered read of the queue head), then its
// result is loaded into the result register, and out_valid rises with that
// load. The load waits while the receiver stalls, and the next item is taken
// only after the load, so the block handles one event at a time.
// A finished result waits in the output register while the next event is
// taken; if the receiver still stalls when that event is ready, the block
// holds it and in_ready stays low.
// Reset empties both queues, clears the link, timer and solenoid flags and
// drops any pending result.
module switch_paced_command_arbiter #(
	parameter int QUEUE_DEPTH = spca_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  spca_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output spca_pkg::out_item_t  out_data,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_data
);
	import spca_pkg::*;

	dp_cmd_t cmd;

	spca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	spca_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.out_data (out_data)
	);

`ifndef ASSERT_OFF
	// only one datapath step per cycle
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.decide, cmd.load}))
		else $error("more than one datapath step in a cycle");

	// an accepted item is decided in the next cycle
	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (cmd.decide && !in_ready))
		else $error("accepted item not decided next cycle");

	// a loaded result is presented
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid)
		else $error("loaded result not presented");

	// a timer restart comes only with a dispatch
	a_restart_sent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.restart_timer) |-> out_data.sent)
		else $error("timer restart without dispatch");
`endif

endmodule

// ===== rtl/core/spca_fifo.sv =====
module spca_fifo #(
	parameter int DEPTH = spca_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  spca_pkg::cmd_entry_t  wr_data,
	input  logic                  pop,
	output spca_pkg::cmd_entry_t  rd_data,
	output logic                  full,
	output logic                  nonempty
);
	import spca_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_entry_t     mem [DEPTH];
	cmd_entry_t     rd_data_q;
	logic [AW-1:0]  head_q;
	logic [AW-1:0]  tail_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign rd_data  = rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[tail_q] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (do_pop) begin
			rd_data_q <= mem[head_q];
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				tail_q <= (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (do_pop) begin
				head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/spca_datapath.sv =====
module spca_datapath #(
	parameter int QUEUE_DEPTH = spca_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spca_pkg::dp_cmd_t    cmd,
	input  spca_pkg::in_item_t   in_data,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_data,
	output spca_pkg::out_item_t  out_data
);
	import spca_pkg::*;

	cmd_entry_t entry;
	cmd_entry_t gen_rd;
	cmd_entry_t sw_rd;
	logic       gen_push;
	logic       sw_push;
	logic       gen_pop;
	logic       sw_pop;
	logic       gen_full;
	logic       sw_full;
	logic       gen_nonempty;
	logic       sw_nonempty;
	logic       link_q;
	logic       timer_q;
	logic       solenoid_q;
	logic       dropped_q;
	logic [7:0] off_code_q;
	sel_t       sel;
	sel_t       sel_q;
	out_item_t  out_q;

	// clamp the byte count and zero an unused second byte
	always_comb begin
		entry.b0 = in_data.first_byte;
		entry.n  = (in_data.byte_count > MAX_BYTES) ? MAX_BYTES : in_data.byte_count;
		entry.b1 = (entry.n == MAX_BYTES) ? in_data.second_byte : 8'd0;
	end

	assign gen_push = cmd.accept && (in_data.op == OP_GENERAL);
	assign sw_push  = cmd.accept && (in_data.op == OP_SWITCH);

	// pick the dispatch from the flags left by the event
	always_comb begin
		sel = SEL_NONE;
		if (link_q) begin
			if (timer_q && sw_nonempty) begin
				sel = SEL_SWITCH;
			end else if (timer_q && solenoid_q) begin
				sel = SEL_OFF;
			end else if (gen_nonempty) begin
				sel = SEL_GENERAL;
			end
		end
	end

	assign sw_pop  = cmd.decide && (sel == SEL_SWITCH);
	assign gen_pop = cmd.decide && (sel == SEL_GENERAL);

	spca_fifo #(.DEPTH(QUEUE_DEPTH)) u_gen_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (gen_push),
		.wr_data  (entry),
		.pop      (gen_pop),
		.rd_data  (gen_rd),
		.full     (gen_full),
		.nonempty (gen_nonempty)
	);

	spca_fifo #(.DEPTH(QUEUE_DEPTH)) u_sw_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (sw_push),
		.wr_data  (entry),
		.pop      (sw_pop),
		.rd_data  (sw_rd),
		.full     (sw_full),
		.nonempty (sw_nonempty)
	);

	// hold the flags, the choice and the off code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q     <= 1'b0;
			timer_q    <= 1'b0;
			solenoid_q <= 1'b0;
			dropped_q  <= 1'b0;
			sel_q      <= SEL_NONE;
			off_code_q <= OFF_CODE_RESET;
		end else begin
			if (cfg_we) begin
				off_code_q <= cfg_data;
			end
			if (cmd.accept) begin
				dropped_q <= (gen_push && gen_full) || (sw_push && sw_full);
				if (in_data.op == OP_LINK) begin
					link_q <= 1'b1;
				end
				if (in_data.op == OP_TIMER) begin
					timer_q <= 1'b1;
				end
			end
			if (cmd.decide) begin
				sel_q <= sel;
				case (sel)
					SEL_SWITCH: begin
						solenoid_q <= 1'b1;
						timer_q    <= 1'b0;
						link_q     <= 1'b0;
					end
					SEL_OFF: begin
						solenoid_q <= 1'b0;
						timer_q    <= 1'b0;
						link_q     <= 1'b0;
					end
					SEL_GENERAL: begin
						link_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// build the result item once the queue read has landed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q.dropped <= dropped_q;
			case (sel_q)
				SEL_SWITCH: begin
					out_q.sent          <= 1'b1;
					out_q.out_first     <= sw_rd.b0;
					out_q.out_second    <= sw_rd.b1;
					out_q.out_count     <= sw_rd.n;
					out_q.restart_timer <= 1'b1;
				end
				SEL_OFF: begin
					out_q.sent          <= 1'b1;
					out_q.out_first     <= off_code_q;
					out_q.out_second    <= 8'd0;
					out_q.out_count     <= 2'd1;
					out_q.restart_timer <= 1'b1;
				end
				SEL_GENERAL: begin
					out_q.sent          <= 1'b1;
					out_q.out_first     <= gen_rd.b0;
					out_q.out_second    <= gen_rd.b1;
					out_q.out_count     <= gen_rd.n;
					out_q.restart_timer <= 1'b0;
				end
				default: begin
					out_q.sent          <= 1'b0;
					out_q.out_first     <= 8'd0;
					out_q.out_second    <= 8'd0;
					out_q.out_count     <= 2'd0;
					out_q.restart_timer <= 1'b0;
				end
			endcase
		end
	end

	assign out_data = out_q;

endmodule

// ===== rtl/core/spca_ctrl.sv =====
module spca_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output spca_pkg::dp_cmd_t  cmd
);
	import spca_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// state register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.decide = 1'b0;
		cmd.load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
